/* sv/ebp_pkg.sv */
// Shared types, constants and helper functions for the block edge profiler.
// Used by ebp_engine, ebp_rsp_fifo and the top level; depends on nothing else.

package ebp_pkg;

   localparam int BLOCK_ENTRIES = 4096;
   localparam int COUNT_WIDTH   = 32;

   localparam int IDX_W  = 12;
   localparam int ADDR_W = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
   localparam int OUT_W  = 32;
   localparam int WIDE_W = 17;

   localparam int REQ_TDATA_W = ((IDX_W + 7) / 8) * 8;
   localparam int RSP_BITS    = 3 * OUT_W + IDX_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic {
      FUNC_VISIT = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   // One entry of the edge store, kept per block.
   typedef struct packed {
      logic [IDX_W-1:0]       succ;
      logic [COUNT_WIDTH-1:0] first_cnt;
      logic [COUNT_WIDTH-1:0] other_cnt;
   } edge_type;

   // Result fields, the first field in the highest bits.
   typedef struct packed {
      logic [OUT_W-1:0] other_successor_count;
      logic [OUT_W-1:0] first_successor_count;
      logic [IDX_W-1:0] first_successor;
      logic [OUT_W-1:0] visit_count;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic read_pending;
   } eng_status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] ext;
      ext = 64'(v);
      if (ext > 64'h0000_0000_FFFF_FFFF) begin
         return '1;
      end
      return ext[OUT_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(idx);
      return wide[ADDR_W-1:0];
   endfunction

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return WIDE_W'(idx) < WIDE_W'(BLOCK_ENTRIES);
   endfunction

endpackage

/* sv/ebp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module ebp_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4,
   parameter int DEPTH  = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

/* sv/ebp_engine.sv */
// Read-modify-write engine of the profiler: visit and edge stores, clearing
// sweep, previous-block register and write forwarding. Uses ebp_pkg and ebp_ram.

module ebp_engine
   import ebp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  func_type         in_func,
   input  logic [IDX_W-1:0] in_index,
   output eng_status_type   status,
   output logic             res_valid,
   output result_type       res
);

   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   logic [ADDR_W-1:0] prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;

   // Second stage: the item whose memory data arrives this cycle.
   logic              s1_valid_ff, s1_valid_in;
   func_type          s1_func_ff;
   logic [IDX_W-1:0]  s1_index_ff;
   logic [ADDR_W-1:0] s1_prev_ff;
   logic              s1_prev_ok_ff;
   logic              s1_range_ff;

   // Last write of each store, for an access that reads it in the same cycle.
   logic                   fw_visit_en_ff;
   logic [ADDR_W-1:0]      fw_visit_addr_ff;
   logic [COUNT_WIDTH-1:0] fw_visit_data_ff;
   logic                   fw_edge_en_ff;
   logic [ADDR_W-1:0]      fw_edge_addr_ff;
   edge_type               fw_edge_data_ff;

   logic [ADDR_W-1:0]      in_addr;
   logic                   in_ok;
   logic [ADDR_W-1:0]      edge_raddr;

   logic                   visit_we;
   logic [ADDR_W-1:0]      visit_waddr;
   logic [COUNT_WIDTH-1:0] visit_wdata;
   logic [COUNT_WIDTH-1:0] visit_rdata;
   logic                   edge_we;
   logic [ADDR_W-1:0]      edge_waddr;
   edge_type               edge_wdata;
   edge_type               edge_rdata;

   logic [ADDR_W-1:0]      s1_addr;
   logic [ADDR_W-1:0]      s1_edge_addr;
   logic [COUNT_WIDTH-1:0] visit_cur;
   edge_type               edge_cur;
   edge_type               edge_new;
   logic                   do_visit;
   logic                   do_edge;

   assign in_addr    = to_addr(in_index);
   assign in_ok      = in_range(in_index);
   assign edge_raddr = (in_func == FUNC_READ) ? in_addr : prev_ff;

   assign s1_addr      = to_addr(s1_index_ff);
   assign s1_edge_addr = (s1_func_ff == FUNC_READ) ? s1_addr : s1_prev_ff;

   always_comb begin
      visit_cur = visit_rdata;
      if (fw_visit_en_ff && (fw_visit_addr_ff == s1_addr)) begin
         visit_cur = fw_visit_data_ff;
      end
      edge_cur = edge_rdata;
      if (fw_edge_en_ff && (fw_edge_addr_ff == s1_edge_addr)) begin
         edge_cur = fw_edge_data_ff;
      end
   end

   assign do_visit = s1_valid_ff && (s1_func_ff == FUNC_VISIT) && s1_range_ff;
   assign do_edge  = do_visit && s1_prev_ok_ff;

   // A zero first-successor count means no successor has been taken yet.
   always_comb begin
      edge_new = edge_cur;
      if (edge_cur.first_cnt == '0) begin
         edge_new.succ = s1_index_ff;
      end
      if (edge_new.succ == s1_index_ff) begin
         edge_new.first_cnt = sat_inc(edge_cur.first_cnt);
      end else begin
         edge_new.other_cnt = sat_inc(edge_cur.other_cnt);
      end
   end

   always_comb begin
      if (clear_ff) begin
         visit_we    = 1'b1;
         visit_waddr = clear_addr_ff;
         visit_wdata = '0;
         edge_we     = 1'b1;
         edge_waddr  = clear_addr_ff;
         edge_wdata  = '0;
      end else begin
         visit_we    = do_visit;
         visit_waddr = s1_addr;
         visit_wdata = sat_inc(visit_cur);
         edge_we     = do_edge;
         edge_waddr  = s1_prev_ff;
         edge_wdata  = edge_new;
      end
   end

   ebp_ram #(
      .DATA_W (COUNT_WIDTH),
      .ADDR_W (ADDR_W),
      .DEPTH  (BLOCK_ENTRIES)
   ) u_visit_ram (
      .clock (clock),
      .we    (visit_we),
      .waddr (visit_waddr),
      .wdata (visit_wdata),
      .re    (in_accept),
      .raddr (in_addr),
      .rdata (visit_rdata)
   );

   ebp_ram #(
      .DATA_W ($bits(edge_type)),
      .ADDR_W (ADDR_W),
      .DEPTH  (BLOCK_ENTRIES)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .re    (in_accept),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_W'(BLOCK_ENTRIES - 1)) begin
            clear_in = 1'b0;
         end
      end
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      if (in_accept && (in_func == FUNC_VISIT) && in_ok) begin
         prev_in       = in_addr;
         prev_valid_in = 1'b1;
      end
      s1_valid_in = in_accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clear_addr_ff  <= '0;
         prev_ff        <= '0;
         prev_valid_ff  <= 1'b0;
         s1_valid_ff    <= 1'b0;
         fw_visit_en_ff <= 1'b0;
         fw_edge_en_ff  <= 1'b0;
      end else begin
         clear_ff       <= clear_in;
         clear_addr_ff  <= clear_addr_in;
         prev_ff        <= prev_in;
         prev_valid_ff  <= prev_valid_in;
         s1_valid_ff    <= s1_valid_in;
         fw_visit_en_ff <= visit_we;
         fw_edge_en_ff  <= edge_we;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff       <= in_func;
      s1_index_ff      <= in_index;
      s1_prev_ff       <= prev_ff;
      s1_prev_ok_ff    <= prev_valid_ff;
      s1_range_ff      <= in_ok;
      fw_visit_addr_ff <= visit_waddr;
      fw_visit_data_ff <= visit_wdata;
      fw_edge_addr_ff  <= edge_waddr;
      fw_edge_data_ff  <= edge_wdata;
   end

   assign res_valid = s1_valid_ff && (s1_func_ff == FUNC_READ);

   always_comb begin
      res = '0;
      if (s1_range_ff) begin
         res.visit_count           = clip_out(visit_cur);
         res.first_successor       = edge_cur.succ;
         res.first_successor_count = clip_out(edge_cur.first_cnt);
         res.other_successor_count = clip_out(edge_cur.other_cnt);
      end
   end

   assign status.clearing     = clear_ff;
   assign status.read_pending = res_valid;

endmodule

/* sv/ebp_rsp_fifo.sv */
// Small result queue between the engine and the result channel.
// Uses ebp_pkg.

module ebp_rsp_fifo
   import ebp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  result_type           push_data,
   input  logic                 pop_ready,
   output logic                 out_valid,
   output result_type           out_data,
   output logic [RSP_LVL_W-1:0] level
);

   result_type           slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0] count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign level     = count_ff;
   assign pop       = out_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + RSP_LVL_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - RSP_LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/block_edge_profiler.sv */
// Basic-block visit and edge profiler, top level.
// Uses ebp_pkg, ebp_engine and ebp_rsp_fifo.
//
// Usage:
// The request channel (req_*) carries one item per transfer: req_tuser is the
// function (0 logs a visit to block req_tdata, 1 reads that block's entry).
// A visit updates the block's visit count and the successor record of the
// block visited before it; it returns nothing. A read returns one transfer on
// the response channel (rsp_*) with the entry's four values.
// One item is taken per cycle while req_tready is high. Each item reads the two
// stores in the cycle it is accepted and writes them back in the next, so one read
// port and one write port per store set the rate; back-to-back items on the same
// entry are served by forwarding the last write.
// A read result passes the second-stage register and the result queue on its way to rsp_tvalid.
// Results wait in a four-entry queue; when the receiver holds rsp_tready low,
// req_tready falls as soon as the queue and a read still in flight could
// fill it, and nothing is lost.
// After reset the stores are swept to zero, one entry per cycle, over all
// BLOCK_ENTRIES (4096) entries; req_tready stays low until the sweep ends.

module block_edge_profiler
   import ebp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // block_index
   input  logic                   req_tuser,   // func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // visit_count, first_successor, first_successor_count, other_successor_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   eng_status_type       status;
   logic                 req_xfer;
   logic                 res_valid;
   result_type           res;
   result_type           rsp_data;
   logic [RSP_LVL_W-1:0] level;
   logic [RSP_LVL_W:0]   committed;

   // Room must remain for a read in flight and the one accepted now.
   assign committed  = (RSP_LVL_W + 1)'(level) + (RSP_LVL_W + 1)'(status.read_pending);
   assign req_tready = !status.clearing && (committed <= (RSP_LVL_W + 1)'(RSP_DEPTH - 1));
   assign req_xfer   = req_tvalid && req_tready;

   ebp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_xfer),
      .in_func   (func_type'(req_tuser)),
      .in_index  (req_tdata[IDX_W-1:0]),
      .status    (status),
      .res_valid (res_valid),
      .res       (res)
   );

   ebp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data),
      .level     (level)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_data);

`ifndef ASSERT_OFF
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) status.clearing |-> !req_tready
   ) else $error("request accepted during the clearing sweep");

   a_read_gives_result: assert property (
      @(posedge clock) disable iff (reset)
      (req_xfer && (func_type'(req_tuser) == FUNC_READ)) |=> res_valid
   ) else $error("read request produced no result in the next cycle");

   a_visit_gives_none: assert property (
      @(posedge clock) disable iff (reset)
      (req_xfer && (func_type'(req_tuser) == FUNC_VISIT)) |=> !res_valid
   ) else $error("visit request produced a result");

   a_queue_no_overflow: assert property (
      @(posedge clock) disable iff (reset)
      !(res_valid && (level == RSP_LVL_W'(RSP_DEPTH)) && !rsp_tready)
   ) else $error("result pushed into a full queue");
`endif

endmodule

/* dv/tb_block_edge_profiler.sv */
`timescale 1ns / 100ps
// Self-checking testbench for block_edge_profiler: directed rows, then random
// visit and read traffic under four idle phases, checked against a local predictor.
// Depends on ebp_pkg and the block_edge_profiler RTL.

module tb_block_edge_profiler;
   import ebp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 440;   // per idle phase
   localparam int HOT_BLOCKS   = 6;
   localparam int SETTLE       = 16;

   typedef struct {
      func_type         func;
      logic [IDX_W-1:0] block;
      bit               typed;
      result_type       result;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // block_index
   logic                   req_tuser = 1'b0; // func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // visit_count, first_successor, first_successor_count, other_successor_count
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Predictor state: a private copy of the profile tables.
   bit [COUNT_WIDTH-1:0] visit_profile [BLOCK_ENTRIES];
   bit [IDX_W-1:0]       succ_profile  [BLOCK_ENTRIES];
   bit [COUNT_WIDTH-1:0] first_profile [BLOCK_ENTRIES];
   bit [COUNT_WIDTH-1:0] other_profile [BLOCK_ENTRIES];
   bit [IDX_W-1:0]       last_block = '0;
   bit                   last_known = 1'b0;

   result_type   pending_reads [$];
   stim_row_type directed [$];

   // Typed expectation for the item now on the request channel.
   bit         row_typed = 1'b0;
   result_type row_result = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int items_taken    = 0;
   int reads_taken    = 0;
   int results_checked = 0;
   int unsigned cycle_count = 0;

   block_edge_profiler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d reads outstanding.",
                  cycle_count, pending_reads.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic bit [COUNT_WIDTH-1:0] bump(input bit [COUNT_WIDTH-1:0] v);
      return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Counters wider than the result field stick at the field's maximum.
   function automatic logic [OUT_W-1:0] report_count(input bit [COUNT_WIDTH-1:0] v);
      return (64'(v) > 64'(32'hFFFF_FFFF)) ? {OUT_W{1'b1}} : OUT_W'(v);
   endfunction

   // Applies one item to the tables; returns 1 when the item yields a result.
   function automatic bit profile_step(input func_type func, input logic [IDX_W-1:0] block,
                                       output result_type res);
      res = '0;
      if (func == FUNC_READ) begin
         if (int'(block) < BLOCK_ENTRIES) begin
            res.visit_count           = report_count(visit_profile[block]);
            res.first_successor       = succ_profile[block];
            res.first_successor_count = report_count(first_profile[block]);
            res.other_successor_count = report_count(other_profile[block]);
         end
         return 1'b1;
      end
      if (int'(block) >= BLOCK_ENTRIES) begin
         return 1'b0;
      end
      visit_profile[block] = bump(visit_profile[block]);
      if (last_known && int'(last_block) < BLOCK_ENTRIES) begin
         // The first successor stays open until the first transition is counted.
         if (first_profile[last_block] == '0) begin
            succ_profile[last_block] = block;
         end
         if (succ_profile[last_block] == block) begin
            first_profile[last_block] = bump(first_profile[last_block]);
         end else begin
            other_profile[last_block] = bump(other_profile[last_block]);
         end
      end
      last_block = block;
      last_known = 1'b1;
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            items_taken++;
            if (profile_step(func_type'(req_tuser), req_tdata[IDX_W-1:0], want)) begin
               reads_taken++;
               pending_reads.push_back(row_typed ? row_result : want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RSP_BITS-1:0]);
            if (pending_reads.size() == 0) begin
               $error("response transfer with no read outstanding");
               fail_count++;
            end else begin
               want = pending_reads.pop_front();
               check_field("visit_count", want.visit_count, got.visit_count);
               check_field("first_successor", 32'(want.first_successor),
                           32'(got.first_successor));
               check_field("first_successor_count", want.first_successor_count,
                           got.first_successor_count);
               check_field("other_successor_count", want.other_successor_count,
                           got.other_successor_count);
               results_checked++;
            end
         end
      end
   end

   function automatic void add_row(input func_type func, input logic [IDX_W-1:0] block,
                                   input bit typed = 1'b0,
                                   input logic [OUT_W-1:0] visits = '0,
                                   input logic [IDX_W-1:0] succ = '0,
                                   input logic [OUT_W-1:0] first_cnt = '0,
                                   input logic [OUT_W-1:0] other_cnt = '0);
      stim_row_type row;
      row.func  = func;
      row.block = block;
      row.typed = typed;
      row.result.visit_count           = visits;
      row.result.first_successor       = succ;
      row.result.first_successor_count = first_cnt;
      row.result.other_successor_count = other_cnt;
      directed.push_back(row);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic push_item(input func_type func, input logic [IDX_W-1:0] block,
                            input bit typed, input result_type result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      row_typed  = typed;
      row_result = result;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_TDATA_W'(block);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Holds the request channel idle until every read has been answered.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_reads.size() != 0);
   endtask

   initial begin
      logic [IDX_W-1:0] hot [HOT_BLOCKS];
      logic [IDX_W-1:0] block;
      func_type         func;
      int               pick;

      // Reads of untouched entries, a first visit with no predecessor, a self
      // transition, and a later transition to a block other than the first.
      add_row(FUNC_READ,  12'h000, 1'b1);
      add_row(FUNC_READ,  12'hFFF, 1'b1);
      add_row(FUNC_READ,  12'hAAA, 1'b1);
      add_row(FUNC_VISIT, 12'h000);
      add_row(FUNC_READ,  12'h000, 1'b1, 32'd1);
      add_row(FUNC_VISIT, 12'hFFF);
      add_row(FUNC_READ,  12'h000, 1'b1, 32'd1, 12'hFFF, 32'd1);
      add_row(FUNC_VISIT, 12'hFFF);
      add_row(FUNC_READ,  12'hFFF, 1'b1, 32'd2, 12'hFFF, 32'd1);
      add_row(FUNC_VISIT, 12'h000);
      add_row(FUNC_VISIT, 12'h555);
      add_row(FUNC_VISIT, 12'h000);
      add_row(FUNC_VISIT, 12'hFFF);
      add_row(FUNC_VISIT, 12'h000);
      add_row(FUNC_READ,  12'h000);
      add_row(FUNC_READ,  12'h555);
      add_row(FUNC_READ,  12'hFFF);
      add_row(FUNC_READ,  12'h7FF, 1'b1);
      add_row(FUNC_VISIT, 12'h7FF);
      add_row(FUNC_VISIT, 12'h800);
      add_row(FUNC_VISIT, 12'h7FF);
      add_row(FUNC_VISIT, 12'h7FF);
      add_row(FUNC_READ,  12'h7FF);
      add_row(FUNC_READ,  12'h800);

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         push_item(directed[r].func, directed[r].block, directed[r].typed, directed[r].result);
      end
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         // A small working set keeps revisiting the same edges.
         hot[0] = '0;
         hot[1] = '1;
         for (int h = 2; h < HOT_BLOCKS; h++) begin
            hot[h] = IDX_W'($urandom_range(BLOCK_ENTRIES - 1));
         end
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            func = ($urandom_range(99) < 25) ? FUNC_READ : FUNC_VISIT;
            pick = $urandom_range(99);
            if (pick < 80) begin
               block = hot[$urandom_range(HOT_BLOCKS - 1)];
            end else begin
               block = IDX_W'($urandom_range(BLOCK_ENTRIES - 1));
            end
            push_item(func, block, 1'b0, '0);
            if (n == RANDOM_ITEMS / 2) begin
               drain_results();
            end
         end
         drain_results();
      end

      repeat (SETTLE) @(posedge clock);
      if (pending_reads.size() != 0) begin
         $error("%0d reads never answered", pending_reads.size());
         fail_count++;
      end
      $display("Sent %0d items (%0d reads) over four idle phases; %0d responses compared.",
               items_taken, reads_taken, results_checked);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/ebp_pkg.sv
sv/ebp_ram.sv
sv/ebp_engine.sv
sv/ebp_rsp_fifo.sv
sv/block_edge_profiler.sv
dv/tb_block_edge_profiler.sv
